### rtl/core/pqem_pkg.sv
// shared types and constants for the extract-max priority queue
`timescale 1ns / 1ps

package pqem_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int COUNT_W  = $clog2(CAPACITY + 1);
  localparam int VALUE_W  = 32;
  localparam int PRI_W    = 16;
  localparam int ECOUNT_W = 8;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef enum logic [1:0] {
    ST_INSERTED = 2'd0,
    ST_REMOVED  = 2'd1,
    ST_FULL     = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef struct packed {
    logic                      kind;
    logic signed [VALUE_W-1:0] item_value;
    logic signed [PRI_W-1:0]   item_priority;
  } in_item_t;

  typedef struct packed {
    status_t                   status;
    logic signed [VALUE_W-1:0] out_value;
    logic signed [PRI_W-1:0]   out_priority;
    logic [ECOUNT_W-1:0]       entry_count;
  } out_item_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic signed [PRI_W-1:0]   prio;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    addr_t  raddr;
  } mem_req_t;

endpackage

### rtl/core/priority_queue_extract_max.sv
// top level of the extract-max priority queue with output register
`timescale 1ns / 1ps

// bounded priority queue of value and signed priority pairs, extract-max order
// request channel: req_valid / req_stall carry one beat, req.kind picks insert or remove
// response channel: rsp_valid / rsp_stall, exactly one response beat per request beat
// insert: pair appended at the tail of the entry store, or status full if no room
// remove: pair with the greatest priority returned and deleted, earliest first on ties;
//   status empty with zero payload if nothing is stored
// every response carries the entry count after the operation
// insert or rejected request: the sequencer moves from idle to its emit state, then hands the
//   result to the response register
// remove of n stored pairs: a max scan over the stored pairs, then a close-up shift of the pairs
//   behind the removed one; both are paced by the single read port of the entry store
// one request is worked on at a time; a new one is taken as soon as the previous result
//   has moved into the response register, even while that beat is stalled
// reset clears the entry count, the sequencer state and the response valid; the store holds no valid pairs afterwards
// a stalled response holds its beat; the sequencer waits with its next result until free
module priority_queue_extract_max (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  pqem_pkg::in_item_t   req,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output pqem_pkg::out_item_t  rsp
);

  // sequencer to store
  pqem_pkg::mem_req_t  mem_req;
  pqem_pkg::entry_t    rd_data;

  // sequencer result hand-over
  logic                res_valid;
  logic                res_ready;
  pqem_pkg::out_item_t res;

  pqem_mem u_mem (
    .clk     (clk),
    .mem_req (mem_req),
    .rd_data (rd_data)
  );

  pqem_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // response register takes a new beat when empty or when its beat leaves
  assign res_ready = !rsp_valid || !rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

`ifndef SYNTHESIS
  // a result held back by a full response register must not change
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res))
    else $error("sequencer result changed while waiting");

  // only a non-stalled insert beat may write while the sequencer is idle
  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    mem_req.we && !req_stall |-> req_valid && req.kind == pqem_pkg::KIND_INSERT)
    else $error("store written without an insert beat");

  // payload is zero unless a pair was removed
  a_zero_payload: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != pqem_pkg::ST_REMOVED |->
      rsp.out_value == '0 && rsp.out_priority == '0)
    else $error("non-remove response with payload");

  // a response is always present the cycle after a result is handed over
  a_handover: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_ready |=> rsp_valid)
    else $error("result lost at hand-over");
`endif

endmodule

### rtl/core/pqem_mem.sv
// entry store: one write port, one registered read port
`timescale 1ns / 1ps

module pqem_mem (
  input  logic                clk,
  input  pqem_pkg::mem_req_t  mem_req,
  output pqem_pkg::entry_t    rd_data
);

  pqem_pkg::entry_t mem [pqem_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[mem_req.raddr];
  end

endmodule

### rtl/core/pqem_ctrl.sv
// sequencer: append, max scan and close-up shift over the entry store
`timescale 1ns / 1ps

module pqem_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  input  pqem_pkg::in_item_t   req,
  output logic                 req_stall,
  output pqem_pkg::mem_req_t   mem_req,
  input  pqem_pkg::entry_t     rd_data,
  output logic                 res_valid,
  output pqem_pkg::out_item_t  res,
  input  logic                 res_ready
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_SHIFT = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t                   state;
  pqem_pkg::count_t         count;
  pqem_pkg::count_t         idx;
  pqem_pkg::addr_t          best_idx;
  pqem_pkg::entry_t         best;
  pqem_pkg::status_t        res_status;
  pqem_pkg::entry_t         res_entry;

  logic                     is_better;
  pqem_pkg::addr_t          scan_best_idx;
  pqem_pkg::entry_t         scan_best;
  logic                     scan_last;
  logic                     best_is_tail;
  pqem_pkg::count_t         last_idx;

  assign last_idx      = count - pqem_pkg::count_t'(1);
  // earliest wins on ties: only a strictly greater priority takes over
  assign is_better     = (idx == '0) || ($signed(rd_data.prio) > $signed(best.prio));
  assign scan_best_idx = is_better ? pqem_pkg::addr_t'(idx) : best_idx;
  assign scan_best     = is_better ? rd_data : best;
  assign scan_last     = (idx == last_idx);
  assign best_is_tail  = (pqem_pkg::count_t'(scan_best_idx) == last_idx);

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_EMIT);

  always_comb begin
    res.status       = res_status;
    res.out_value    = res_entry.value;
    res.out_priority = res_entry.prio;
    res.entry_count  = pqem_pkg::ECOUNT_W'(count);
  end

  always_comb begin
    mem_req.we          = 1'b0;
    mem_req.waddr       = pqem_pkg::addr_t'(count);
    mem_req.wdata.value = req.item_value;
    mem_req.wdata.prio  = req.item_priority;
    mem_req.raddr       = '0;
    case (state)
      S_IDLE: begin
        if (req_valid && req.kind == pqem_pkg::KIND_INSERT &&
            count != pqem_pkg::count_t'(pqem_pkg::CAPACITY)) begin
          mem_req.we = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          mem_req.raddr = pqem_pkg::addr_t'(scan_best_idx + pqem_pkg::addr_t'(1));
        end else begin
          mem_req.raddr = pqem_pkg::addr_t'(idx + pqem_pkg::count_t'(1));
        end
      end
      S_SHIFT: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pqem_pkg::addr_t'(idx);
        mem_req.wdata = rd_data;
        mem_req.raddr = pqem_pkg::addr_t'(idx + pqem_pkg::count_t'(2));
      end
      default: begin
        mem_req.raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            if (req.kind == pqem_pkg::KIND_INSERT) begin
              if (count == pqem_pkg::count_t'(pqem_pkg::CAPACITY)) begin
                res_status <= pqem_pkg::ST_FULL;
              end else begin
                res_status <= pqem_pkg::ST_INSERTED;
                count      <= count + pqem_pkg::count_t'(1);
              end
              res_entry <= '0;
              state     <= S_EMIT;
            end else if (count == '0) begin
              res_status <= pqem_pkg::ST_EMPTY;
              res_entry  <= '0;
              state      <= S_EMIT;
            end else begin
              idx   <= '0;
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          best     <= scan_best;
          best_idx <= scan_best_idx;
          if (scan_last) begin
            res_status <= pqem_pkg::ST_REMOVED;
            res_entry  <= scan_best;
            if (best_is_tail) begin
              count <= last_idx;
              state <= S_EMIT;
            end else begin
              idx   <= pqem_pkg::count_t'(scan_best_idx);
              state <= S_SHIFT;
            end
          end else begin
            idx <= idx + pqem_pkg::count_t'(1);
          end
        end
        S_SHIFT: begin
          if (idx + pqem_pkg::count_t'(2) == count) begin
            count <= last_idx;
            state <= S_EMIT;
          end else begin
            idx <= idx + pqem_pkg::count_t'(1);
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
